@@ rtl/program_image_loader_parser_assert.svh @@
// Assertion macros shared by the program image loader parser modules.
`ifndef PROGRAM_IMAGE_LOADER_PARSER_ASSERT_SVH
`define PROGRAM_IMAGE_LOADER_PARSER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PILP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that implies a consequence at the next clock edge.
`define PILP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pilp_pkg.sv @@
// Package with the constants, types and character helpers of the image loader parser.
`default_nettype none

package pilp_pkg;

  // Image geometry.
  localparam int IMAGE_WORDS = 256;
  localparam int ROW_WORDS   = 16;

  // Position and count limits.
  localparam int ROW_W    = 5;
  localparam int ROW_MAX  = 31;
  localparam int BODY_W   = 8;
  localparam int BODY_MAX = 255;

  // The column holds a hex digit from a position word or any in-row index.
  localparam int COL_W       = (ROW_WORDS > 16) ? $clog2(ROW_WORDS) : 4;
  localparam int ADDR_FULL_W = COL_W + ROW_W + 1;
  localparam int WADDR_W     = 8;
  localparam int WORD_W      = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] HEADER_MAGIC_RESET = 32'h4A4D_4124;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_END        = 3'd2,
    ST_BODY_LIMIT = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_IGNORED    = 3'd5
  } status_t;

  // What the back end has to do with a classified word.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RAW  = 2'd1,
    KIND_HEX  = 2'd2
  } kind_t;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    kind_t                  kind;
    status_t                status;
    logic [ADDR_FULL_W-1:0] addr;
    logic [WORD_W-1:0]      word;
  } cmd_t;

  // True for an uppercase hex digit.
  function automatic logic is_hex(input logic [7:0] ch);
    return ((ch >= 8'h30) && (ch <= 8'h39)) || ((ch >= 8'h41) && (ch <= 8'h46));
  endfunction

  // Value of an uppercase hex digit; meaningful only when is_hex holds.
  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] v;
    if (ch <= 8'h39) begin
      v = ch - 8'h30;
    end else begin
      v = ch - 8'h37;
    end
    return v[3:0];
  endfunction

  // True for a printable character.
  function automatic logic is_print(input logic [7:0] ch);
    return (ch >= 8'd32) && (ch <= 8'd126);
  endfunction

  // Packs four characters into a word, first character lowest.
  function automatic logic [WORD_W-1:0] chars4(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic [7:0] d);
    return {d, c, b, a};
  endfunction

  // True for the two-letter opcodes that take two hex digits.
  function automatic logic is_two_op(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    logic        hit;
    p = {a, b};
    case (p)
      {"J", "P"}, {"J", "Z"}, {"J", "N"}, {"J", "B"}, {"J", "A"},
      {"M", "A"}, {"M", "B"}, {"S", "A"}, {"S", "B"}, {"A", "D"},
      {"S", "U"}, {"M", "U"}, {"D", "I"}: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // True for the four-letter opcodes without operand.
  function automatic logic is_zero_op(input logic [WORD_W-1:0] w);
    return (w == chars4("R", "E", "A", "D")) || (w == chars4("P", "N", "U", "M")) ||
           (w == chars4("P", "T", "X", "T")) || (w == chars4("A", "N", "D", "_")) ||
           (w == chars4("O", "R", "_", "_")) || (w == chars4("N", "O", "T", "_")) ||
           (w == chars4("H", "A", "L", "T")) || (w == chars4("C", "M", "P", "_"));
  endfunction

endpackage

`default_nettype wire

@@ rtl/pilp_queue.sv @@
// Two-entry command queue between the parser front end and the write back end.
`default_nettype none

`include "program_image_loader_parser_assert.svh"

module pilp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pilp_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output pilp_pkg::cmd_t       pop_cmd,
  output logic                 empty
);

  pilp_pkg::cmd_t                    slots [pilp_pkg::QUEUE_DEPTH];
  logic [pilp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [pilp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [pilp_pkg::QCNT_W-1:0]       count;

  assign full    = (count == pilp_pkg::QCNT_W'(pilp_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PILP_ASSERT(a_no_overflow, !(push && full && !pop), "push into a full queue")
  `PILP_ASSERT(a_no_underflow, !(pop && empty), "pop from an empty queue")
  `PILP_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not grow")

endmodule

`default_nettype wire

@@ rtl/pilp_front.sv @@
// Front end: classifies each text word and tracks the parsing position.
`default_nettype none

`include "program_image_loader_parser_assert.svh"

module pilp_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [pilp_pkg::WORD_W-1:0] header_magic,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        start_req,
  input  wire logic [pilp_pkg::WORD_W-1:0] text_word,
  output logic                             push,
  output pilp_pkg::cmd_t                   push_cmd,
  input  wire logic                        queue_full
);

  logic                           running;
  logic [pilp_pkg::ROW_W-1:0]     row;
  logic [pilp_pkg::COL_W-1:0]     column;
  logic [pilp_pkg::BODY_W-1:0]    body_count;

  logic                           running_next;
  logic [pilp_pkg::ROW_W-1:0]     row_next;
  logic [pilp_pkg::COL_W-1:0]     column_next;
  logic [pilp_pkg::BODY_W-1:0]    body_count_next;

  logic [7:0]                     c0, c1, c2, c3;
  logic                           is_pos, is_end, is_instr, is_hex4, is_text;
  logic [pilp_pkg::COL_W:0]       col_inc;
  logic [pilp_pkg::ADDR_FULL_W-1:0] cur_addr;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  assign c0 = text_word[7:0];
  assign c1 = text_word[15:8];
  assign c2 = text_word[23:16];
  assign c3 = text_word[31:24];

  // Word classes.
  always_comb begin
    is_pos   = (c0 == "$") && (c1 == "x") && pilp_pkg::is_hex(c2) && pilp_pkg::is_hex(c3);
    is_end   = (text_word == pilp_pkg::chars4("!", "!", "!", "!"));
    is_instr = ((c0 == "$") && pilp_pkg::is_hex(c1) && (c2 == "0") && (c3 == "0")) ||
               (pilp_pkg::is_two_op(c0, c1) && pilp_pkg::is_hex(c2) && pilp_pkg::is_hex(c3)) ||
               ((c0 == "E") && (c1 == "X") && (c2 == "E") && pilp_pkg::is_hex(c3)) ||
               pilp_pkg::is_zero_op(text_word);
    is_hex4  = pilp_pkg::is_hex(c0) && pilp_pkg::is_hex(c1) &&
               pilp_pkg::is_hex(c2) && pilp_pkg::is_hex(c3);
    is_text  = pilp_pkg::is_print(c0) && pilp_pkg::is_print(c1) &&
               pilp_pkg::is_print(c2) && pilp_pkg::is_print(c3);
  end

  // Current write address, row times the row length plus the column.
  assign cur_addr = pilp_pkg::ADDR_FULL_W'(row) * pilp_pkg::ADDR_FULL_W'(pilp_pkg::ROW_WORDS) +
                    pilp_pkg::ADDR_FULL_W'(column);
  assign col_inc  = {1'b0, column} + 1'b1;

  // Next parsing state and the command for the back end.
  always_comb begin
    running_next    = running;
    row_next        = row;
    column_next     = column;
    body_count_next = body_count;
    push_cmd.kind   = pilp_pkg::KIND_NONE;
    push_cmd.status = pilp_pkg::ST_OK;
    push_cmd.addr   = cur_addr;
    push_cmd.word   = text_word;
    if (start_req) begin
      row_next        = '0;
      column_next     = '0;
      body_count_next = '0;
      running_next    = (text_word == header_magic);
      push_cmd.status = (text_word == header_magic) ? pilp_pkg::ST_OK : pilp_pkg::ST_BAD_HEADER;
    end else if (!running) begin
      push_cmd.status = pilp_pkg::ST_IGNORED;
    end else if (body_count >= pilp_pkg::BODY_W'(pilp_pkg::BODY_MAX)) begin
      push_cmd.status = pilp_pkg::ST_BODY_LIMIT;
      running_next    = 1'b0;
    end else begin
      body_count_next = body_count + 1'b1;
      if (is_pos) begin
        row_next    = pilp_pkg::ROW_W'(pilp_pkg::hex_val(c2));
        column_next = pilp_pkg::COL_W'(pilp_pkg::hex_val(c3));
      end else if (is_end) begin
        push_cmd.status = pilp_pkg::ST_END;
        running_next    = 1'b0;
      end else begin
        if (is_instr) begin
          push_cmd.kind = pilp_pkg::KIND_RAW;
        end else if (is_hex4) begin
          push_cmd.kind = pilp_pkg::KIND_HEX;
        end else if (is_text) begin
          push_cmd.kind = pilp_pkg::KIND_RAW;
        end
        // Advance the column and wrap into the next row, which saturates.
        if (col_inc >= (pilp_pkg::COL_W + 1)'(pilp_pkg::ROW_WORDS)) begin
          column_next = '0;
          if (row < pilp_pkg::ROW_W'(pilp_pkg::ROW_MAX)) begin
            row_next = row + 1'b1;
          end
        end else begin
          column_next = col_inc[pilp_pkg::COL_W-1:0];
        end
      end
    end
  end

  // Parsing state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      row        <= '0;
      column     <= '0;
      body_count <= '0;
    end else if (push) begin
      running    <= running_next;
      row        <= row_next;
      column     <= column_next;
      body_count <= body_count_next;
    end
  end

  `PILP_ASSERT_NEXT(a_end_stops, push && (push_cmd.status == pilp_pkg::ST_END), !running,
                    "end marker did not stop parsing")

endmodule

`default_nettype wire

@@ rtl/pilp_back.sv @@
// Back end: turns queued commands into image writes and holds the result register.
`default_nettype none

`include "program_image_loader_parser_assert.svh"

module pilp_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pilp_pkg::cmd_t               pop_cmd,
  input  wire logic                         queue_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              write_valid,
  output logic [pilp_pkg::WADDR_W-1:0]      write_addr,
  output logic [pilp_pkg::WORD_W-1:0]       write_data,
  output pilp_pkg::status_t                 status
);

  logic                           wv_c;
  logic [pilp_pkg::WADDR_W-1:0]   wa_c;
  logic [pilp_pkg::WORD_W-1:0]    wd_c;
  pilp_pkg::status_t              st_c;
  logic [pilp_pkg::WORD_W-1:0]    data_c;
  logic                           in_image;

  assign pop = !queue_empty && (!out_valid || out_ready);

  // Write data and the image bound check.
  always_comb begin
    case (pop_cmd.kind)
      pilp_pkg::KIND_HEX: data_c = {16'h0000,
                                    pilp_pkg::hex_val(pop_cmd.word[7:0]),
                                    pilp_pkg::hex_val(pop_cmd.word[15:8]),
                                    pilp_pkg::hex_val(pop_cmd.word[23:16]),
                                    pilp_pkg::hex_val(pop_cmd.word[31:24])};
      default:            data_c = pop_cmd.word;
    endcase
    in_image = (32'(pop_cmd.addr) < 32'(pilp_pkg::IMAGE_WORDS));
    wv_c = 1'b0;
    wa_c = '0;
    wd_c = '0;
    st_c = pop_cmd.status;
    if (pop_cmd.kind != pilp_pkg::KIND_NONE) begin
      if (in_image) begin
        wv_c = 1'b1;
        wa_c = pop_cmd.addr[pilp_pkg::WADDR_W-1:0];
        wd_c = data_c;
      end else begin
        st_c = pilp_pkg::ST_OVERFLOW;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      write_valid <= wv_c;
      write_addr  <= wa_c;
      write_data  <= wd_c;
      status      <= st_c;
    end
  end

  // Result beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `PILP_ASSERT(a_write_ok, !(out_valid && write_valid) || (status == pilp_pkg::ST_OK),
               "image write with a non-ok status")

endmodule

`default_nettype wire

@@ rtl/program_image_loader_parser.sv @@
// Top level of the program image loader parser: stream ports, register port and wiring.
//
// Input stream (s_*): one beat per 32-bit text word, first character in bits 7:0.
// s_tuser marks the header beat that restarts parsing and is checked against
// header_magic. Output stream (m_*): exactly one result beat per input beat, in
// order, carrying the image write (valid, address, data) and a status code.
// Throughput is one word per cycle while the receiver keeps up: the front end
// classifies a word and updates the position as it is accepted, and the back
// end forms one result per cycle. An accepted input beat is written into the
// two-entry command queue and loaded into the result register when the back
// end pops it.
// When the receiver stalls, the result register holds its beat, the queue fills,
// and s_tready drops once both queue entries are taken; it rises again in the
// cycle after the receiver takes the held beat.
// Register port: header_magic at byte address 0, written in the access phase;
// pready is always high; reads return the register below byte address 4, else zero.
// Reset (rst, synchronous) clears the queue, the result valid, the parsing state
// (not running, row and column zero, body count zero) and restores header_magic.
`default_nettype none

module program_image_loader_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] text_word
  input  wire logic [0:0]  s_tuser,   // [0] start_req
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] write_addr, [39:8] write_data
  output logic [3:0]       m_tuser,   // [0] write_valid, [3:1] status
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [pilp_pkg::WORD_W-1:0]  header_magic;
  logic                         push;
  pilp_pkg::cmd_t               push_cmd;
  logic                         queue_full;
  logic                         pop;
  pilp_pkg::cmd_t               pop_cmd;
  logic                         queue_empty;
  logic                         write_valid;
  logic [pilp_pkg::WADDR_W-1:0] write_addr;
  logic [pilp_pkg::WORD_W-1:0]  write_data;
  pilp_pkg::status_t            status;

  // Register port: a single register in the lower word slot.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? header_magic : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_magic <= pilp_pkg::HEADER_MAGIC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      header_magic <= pwdata;
    end
  end

  pilp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .header_magic (header_magic),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .start_req    (s_tuser[0]),
    .text_word    (s_tdata),
    .push         (push),
    .push_cmd     (push_cmd),
    .queue_full   (queue_full)
  );

  pilp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  pilp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_cmd     (pop_cmd),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .write_valid (write_valid),
    .write_addr  (write_addr),
    .write_data  (write_data),
    .status      (status)
  );

  // Pack the result beat.
  assign m_tdata = {write_data, write_addr};
  assign m_tuser = {status, write_valid};

endmodule

`default_nettype wire

@@ bench/program_image_loader_parser_test.sv @@
// Self-checking bench for the program image loader parser: stimulus, register writes, scoreboard.
module program_image_loader_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pilp_pkg::*;

  localparam logic [2:0] ADDR_HEADER_MAGIC = 3'd0;
  localparam int         DRAIN_CYCLES      = 8;
  localparam int         HOLD_CYCLES       = 300;
  // The closing body-limit run adds about 260 words on top of this.
  localparam int         ITEM_TARGET       = 1190;

  // One result beat as the block should produce it.
  typedef struct {
    logic        wvalid;
    logic [7:0]  waddr;
    logic [31:0] wdata;
    status_t     st;
  } image_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Parser state as predicted by the bench.
  logic [31:0] mdl_magic;
  bit          mdl_running;
  int          mdl_row;
  int          mdl_col;
  int          mdl_body;

  image_write_t pending_writes[$];
  int           n_errors = 0;
  int           n_items_sent = 0;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;

  string two_op_letters = "JPJZJNJBJAMAMBSASBADSUMUDI";
  string plain_ops [8] = '{"READ", "PNUM", "PTXT", "AND_", "OR__", "NOT_", "HALT", "CMP_"};

  program_image_loader_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] text_word
    .s_tuser  (s_tuser),   // [0] start_req
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] write_addr, [39:8] write_data
    .m_tuser  (m_tuser),   // [0] write_valid, [3:1] status
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Four characters to a word, first character in the low byte.
  function automatic logic [31:0] w4(input string s);
    return {s[3], s[2], s[1], s[0]};
  endfunction

  function automatic logic [31:0] pack_chars(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d);
    return {d, c, b, a};
  endfunction

  // Digit value, 16 for anything that is not an uppercase hex digit.
  function automatic int hexv(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - 48;
    if (ch >= "A" && ch <= "F") return int'(ch) - 55;
    return 16;
  endfunction

  function automatic bit is_opcode(input logic [31:0] w);
    logic [7:0] c0, c1, c2, c3;
    c0 = w[7:0];
    c1 = w[15:8];
    c2 = w[23:16];
    c3 = w[31:24];
    if (c0 == "$" && hexv(c1) < 16 && c2 == "0" && c3 == "0") return 1'b1;
    for (int i = 0; i < 13; i++) begin
      if (c0 == two_op_letters[2*i] && c1 == two_op_letters[2*i+1] &&
          hexv(c2) < 16 && hexv(c3) < 16) return 1'b1;
    end
    if (c0 == "E" && c1 == "X" && c2 == "E" && hexv(c3) < 16) return 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (w == w4(plain_ops[i])) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the result beat for one accepted word and updates the parser state.
  function automatic image_write_t predict_write(input bit start, input logic [31:0] w);
    image_write_t r;
    logic [7:0]   c [4];
    bit           writes;
    bit           all_hex;
    bit           all_print;
    logic [31:0]  data;
    int           a;
    r.wvalid = 1'b0;
    r.waddr = '0;
    r.wdata = '0;
    r.st = ST_OK;
    writes = 1'b0;
    data = '0;
    all_hex = 1'b1;
    all_print = 1'b1;
    for (int i = 0; i < 4; i++) begin
      c[i] = w[8*i +: 8];
      if (hexv(c[i]) >= 16) all_hex = 1'b0;
      if (c[i] < 8'd32 || c[i] > 8'd126) all_print = 1'b0;
    end
    if (start) begin
      mdl_row = 0;
      mdl_col = 0;
      mdl_body = 0;
      mdl_running = (w == mdl_magic);
      r.st = mdl_running ? ST_OK : ST_BAD_HEADER;
    end else if (!mdl_running) begin
      r.st = ST_IGNORED;
    end else if (mdl_body >= BODY_MAX) begin
      r.st = ST_BODY_LIMIT;
      mdl_running = 1'b0;
    end else begin
      mdl_body++;
      if (c[0] == "$" && c[1] == "x" && hexv(c[2]) < 16 && hexv(c[3]) < 16) begin
        mdl_row = hexv(c[2]);
        mdl_col = hexv(c[3]);
      end else if (w == w4("!!!!")) begin
        r.st = ST_END;
        mdl_running = 1'b0;
      end else begin
        if (is_opcode(w)) begin
          writes = 1'b1;
          data = w;
        end else if (all_hex) begin
          writes = 1'b1;
          data = 32'((hexv(c[0]) << 12) | (hexv(c[1]) << 8) | (hexv(c[2]) << 4) | hexv(c[3]));
        end else if (all_print) begin
          writes = 1'b1;
          data = w;
        end
        if (writes) begin
          a = mdl_row * ROW_WORDS + mdl_col;
          if (a < IMAGE_WORDS) begin
            r.wvalid = 1'b1;
            r.waddr = a[7:0];
            r.wdata = data;
          end else begin
            r.st = ST_OVERFLOW;
          end
        end
        // The column advances and wraps into the next row, which saturates.
        mdl_col++;
        if (mdl_col >= ROW_WORDS) begin
          mdl_col = 0;
          if (mdl_row < ROW_MAX) mdl_row++;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] any_hex();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? 8'(48 + v) : 8'(55 + v);
  endfunction

  function automatic logic [7:0] print_char();
    return 8'($urandom_range(32, 126));
  endfunction

  // A character outside the printable range, control codes and high bytes alike.
  function automatic logic [7:0] odd_char();
    int r;
    r = $urandom_range(0, 160);
    return (r < 32) ? 8'(r) : 8'(r + 95);
  endfunction

  // One body word drawn over all word classes.
  function automatic logic [31:0] random_body_word(input bit allow_end);
    int          pick;
    int          k;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w = pack_chars("$", "x", any_hex(), any_hex());
    end else if (pick < 40) begin
      case ($urandom_range(0, 3))
        0: w = pack_chars("$", any_hex(), "0", "0");
        1: begin
          k = $urandom_range(0, 12);
          w = pack_chars(two_op_letters[2*k], two_op_letters[2*k+1], any_hex(), any_hex());
        end
        2: w = pack_chars("E", "X", "E", any_hex());
        default: w = w4(plain_ops[$urandom_range(0, 7)]);
      endcase
    end else if (pick < 60) begin
      w = pack_chars(any_hex(), any_hex(), any_hex(), any_hex());
    end else if (pick < 80) begin
      w = pack_chars(print_char(), print_char(), print_char(), print_char());
    end else if (pick < 90) begin
      w = pack_chars(print_char(), print_char(), print_char(), print_char());
      k = $urandom_range(0, 3);
      w[8*k +: 8] = odd_char();
    end else if (pick < 92 && allow_end) begin
      w = w4("!!!!");
    end else begin
      w = $urandom;
    end
    return w;
  endfunction

  // Offers one beat, waits for it to be taken and records what it should produce.
  task automatic send_word(input bit start, input logic [31:0] word);
    image_write_t want;
    while (!tx_calm && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= start;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    want = predict_write(start, word);
    pending_writes.insert(pending_writes.size(), want);
    n_items_sent++;
  endtask

  // Stops offering and waits until every expected beat has come out.
  task automatic drain_writes();
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic write_magic(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_HEADER_MAGIC;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mdl_magic = value;
  endtask

  task automatic report_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR %0t: %s", $realtime, what);
  endtask

  // Each word class and the edge cases, at the reset header value.
  task automatic test_directed();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    send_word(1'b1, w4("XXXX"));          // wrong header
    send_word(1'b0, w4("READ"));          // not running
    send_word(1'b1, w4("$AMJ"));
    send_word(1'b0, w4("$A00"));
    send_word(1'b0, w4("JP3F"));
    send_word(1'b0, w4("DI00"));
    send_word(1'b0, w4("EXE9"));
    send_word(1'b0, w4("HALT"));
    send_word(1'b0, w4("CMP_"));
    send_word(1'b0, w4("FFFF"));
    send_word(1'b0, w4("0000"));
    send_word(1'b0, w4(" ~~~"));
    send_word(1'b0, 32'h7F41_4141);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b0, w4("JPG0"));          // operand not hex, so it is text
    send_word(1'b0, w4("$xF0"));
    send_word(1'b0, w4("A1B2"));
    send_word(1'b0, w4("$xFF"));
    send_word(1'b0, w4("MU12"));          // last image word
    send_word(1'b0, w4("SUBA"));          // past the image, dropped
    send_word(1'b0, 32'h0102_0304);       // past the image but nothing to write
    send_word(1'b0, w4("!!!!"));
    send_word(1'b0, w4("PNUM"));          // after the end marker
    drain_writes();
  endtask

  // A body that runs into the word limit, starting near the end of the image.
  task automatic test_body_limit();
    send_word(1'b1, mdl_magic);
    send_word(1'b0, w4("$xF8"));
    for (int i = 0; i < BODY_MAX + 1; i++) send_word(1'b0, random_body_word(1'b0));
    send_word(1'b0, w4("READ"));
    drain_writes();
  endtask

  // Header register at its extremes, at a random value and at a four-character text.
  task automatic test_header_settings();
    logic [31:0] values [4];
    values = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, w4("PROG")};
    for (int i = 0; i < 4; i++) begin
      write_magic(values[i]);
      send_word(1'b1, values[i] ^ 32'h0000_0001);
      send_word(1'b0, w4("AND_"));
      send_word(1'b1, values[i]);
      for (int j = 0; j < 4; j++) send_word(1'b0, random_body_word(1'b0));
      drain_writes();
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    tx_calm = 1'b1;
    hold_req = 1'b1;
    send_word(1'b1, mdl_magic);
    for (int i = 0; i < 40; i++) send_word(1'b0, random_body_word(1'b0));
    drain_writes();
    tx_calm = 1'b0;
  endtask

  // Random programs: mostly valid headers and bodies, some noise and broken headers.
  task automatic test_random_programs();
    int          body_len;
    int          pick;
    logic [31:0] header;
    while (n_items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) begin
        drain_writes();
        pick = $urandom_range(0, 3);
        write_magic(pick == 0 ? HEADER_MAGIC_RESET : pick == 1 ? 32'hFFFF_FFFF :
                    pick == 2 ? 32'h0000_0000 : 32'($urandom));
      end
      tx_calm = ($urandom_range(0, 7) == 0);
      rx_calm = tx_calm;
      pick = $urandom_range(0, 99);
      if (pick < 85) header = mdl_magic;
      else if (pick < 95) header = mdl_magic ^ (32'h1 << $urandom_range(0, 31));
      else header = $urandom;
      send_word(1'b1, header);
      pick = $urandom_range(0, 99);
      if (header != mdl_magic) body_len = $urandom_range(0, 4);
      else if (pick < 80) body_len = $urandom_range(1, 40);
      else if (pick < 95) body_len = $urandom_range(41, 120);
      else body_len = $urandom_range(240, 270);
      for (int i = 0; i < body_len; i++) send_word(1'b0, random_body_word(1'b1));
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain_writes();
  endtask

  // Receiver: random stalls, a counted hold-off on request, calm stretches.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 15);
    end
  end

  // Scoreboard: every result beat against the oldest expected write.
  always @(posedge clk) begin : check_results
    image_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        report_error($sformatf("result beat with nothing expected: tdata %h tuser %h",
                               m_tdata, m_tuser));
      end else begin
        want = pending_writes.pop_front();
        if (m_tuser[0] !== want.wvalid || m_tdata[7:0] !== want.waddr ||
            m_tdata[39:8] !== want.wdata || m_tuser[3:1] !== want.st) begin
          report_error($sformatf(
            "expected valid %0b addr %h data %h status %0d, got %0b %h %h %0d",
            want.wvalid, want.waddr, want.wdata, want.st,
            m_tuser[0], m_tdata[7:0], m_tdata[39:8], m_tuser[3:1]));
        end
      end
    end
  end

  initial begin
    mdl_magic = HEADER_MAGIC_RESET;
    mdl_running = 1'b0;
    mdl_row = 0;
    mdl_col = 0;
    mdl_body = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_body_limit();
    test_header_settings();
    test_backpressure();
    test_random_programs();
    write_magic(HEADER_MAGIC_RESET);
    test_body_limit();
    if (n_errors == 0 && pending_writes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pilp_pkg.sv
rtl/pilp_queue.sv
rtl/pilp_front.sv
rtl/pilp_back.sv
rtl/program_image_loader_parser.sv
bench/program_image_loader_parser_test.sv
